>>> design/lpfr_pkg.sv
// ============================================================================
// lpfr_pkg: shared types and constants of the length-prefixed frame receiver
// Status codes, configuration register indexes and the structs that travel
// between the configuration block, the parser and the top level.
// ============================================================================
package lpfr_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned PosW      = 10;
  localparam int unsigned LenW      = 16;
  localparam int unsigned IdxW      = 9;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_SHORT_START = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_START  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN     = 2'd3;

  // Reset values of the registers
  localparam logic [7:0]  RST_SHORT_START = 8'hFE;
  localparam logic [7:0]  RST_LONG_START  = 8'hFD;
  localparam logic [15:0] RST_TIMEOUT     = 16'd1000;
  localparam logic [9:0]  RST_MAX_LEN     = 10'd512;

  // Shortest lengths that still reach the command byte
  localparam logic [LenW-1:0] MIN_LEN_SHORT = 16'd3;
  localparam logic [LenW-1:0] MIN_LEN_LONG  = 16'd4;

  // Command byte offsets
  localparam logic [PosW-1:0] CMD_OFS_SHORT = 10'd2;
  localparam logic [PosW-1:0] CMD_OFS_LONG  = 10'd3;

  localparam logic [15:0] IDLE_SAT = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_DONE    = 3'd2,
    ST_STRAY   = 3'd3,
    ST_BADLEN  = 3'd4,
    ST_TIMEOUT = 3'd5
  } status_e;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0]  short_start;
    logic [7:0]  long_start;
    logic [15:0] timeout;
    logic [9:0]  max_len;
  } cfg_t;

  typedef struct packed {
    kind_e      command;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    status_e         status;
    logic [7:0]      out_byte;
    logic [IdxW-1:0] byte_index;
    logic [LenW-1:0] frame_length;
    logic            long_frame;
    logic [7:0]      command_code;
  } result_t;

endpackage

>>> design/lpfr_cfg_regs.sv
// ============================================================================
// lpfr_cfg_regs: configuration registers
// Plain write port; writes to indexes outside the list are ignored.
// ============================================================================
module lpfr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lpfr_pkg::CfgDataW-1:0] cfg_data_i,
  output lpfr_pkg::cfg_t                cfg_o
);

  lpfr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        lpfr_pkg::CFG_SHORT_START: cfg_d.short_start = cfg_data_i[7:0];
        lpfr_pkg::CFG_LONG_START:  cfg_d.long_start  = cfg_data_i[7:0];
        lpfr_pkg::CFG_TIMEOUT:     cfg_d.timeout     = cfg_data_i[15:0];
        lpfr_pkg::CFG_MAX_LEN:     cfg_d.max_len     = cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_start <= lpfr_pkg::RST_SHORT_START;
      cfg_q.long_start  <= lpfr_pkg::RST_LONG_START;
      cfg_q.timeout     <= lpfr_pkg::RST_TIMEOUT;
      cfg_q.max_len     <= lpfr_pkg::RST_MAX_LEN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/lpfr_parser.sv
// ============================================================================
// lpfr_parser: frame state and per-item decode
// Holds the frame state and computes one result per item; state advances
// when step_i is high.
// ============================================================================
module lpfr_parser #(
  parameter int unsigned MAX_FRAME = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  lpfr_pkg::item_t   item_i,
  input  lpfr_pkg::cfg_t    cfg_i,
  output lpfr_pkg::result_t result_o
);

  localparam logic [lpfr_pkg::LenW-1:0] MaxFrameLen = lpfr_pkg::LenW'(MAX_FRAME);

  logic [lpfr_pkg::PosW-1:0] position_q, position_d;
  logic [lpfr_pkg::LenW-1:0] exp_len_q, exp_len_d;
  logic                      long_q, long_d;
  logic [7:0]                cmd_q, cmd_d;
  logic [15:0]               idle_q, idle_d;

  logic [15:0]               idle_inc;
  logic [lpfr_pkg::LenW-1:0] len_new;
  logic [lpfr_pkg::LenW-1:0] len_need;
  logic                      len_done;
  logic                      len_ok;
  logic [lpfr_pkg::PosW-1:0] pos_inc;
  logic [lpfr_pkg::PosW-1:0] cmd_ofs;
  logic [7:0]                cmd_now;
  logic [7:0]                c;
  logic                      is_short;
  logic                      is_long;

  always_comb begin
    c        = item_i.data_byte;
    is_short = (c == cfg_i.short_start);
    is_long  = (c == cfg_i.long_start);
    idle_inc = (idle_q < lpfr_pkg::IDLE_SAT) ? idle_q + 16'd1 : idle_q;
    pos_inc  = position_q + 10'd1;
    cmd_ofs  = long_q ? lpfr_pkg::CMD_OFS_LONG : lpfr_pkg::CMD_OFS_SHORT;
    cmd_now  = (position_q == cmd_ofs) ? c : cmd_q;
    len_need = long_q ? lpfr_pkg::MIN_LEN_LONG : lpfr_pkg::MIN_LEN_SHORT;

    if (position_q == 10'd1) begin
      len_new  = long_q ? {c, 8'h00} : {8'h00, c};
      len_done = !long_q;
    end else begin
      len_new  = exp_len_q + {8'h00, c};
      len_done = 1'b1;
    end
    len_ok = (len_new >= len_need) && (len_new <= {6'd0, cfg_i.max_len}) &&
             (len_new <= MaxFrameLen);

    position_d = position_q;
    exp_len_d  = exp_len_q;
    long_d     = long_q;
    cmd_d      = cmd_q;
    idle_d     = idle_q;
    result_o   = '0;

    if (item_i.command == lpfr_pkg::KIND_TICK) begin
      if (position_q != '0) begin
        if (idle_inc > cfg_i.timeout) begin
          // drop the stale partial frame
          position_d = '0;
          exp_len_d  = '0;
          long_d     = 1'b0;
          cmd_d      = '0;
          idle_d     = '0;
          result_o.status = lpfr_pkg::ST_TIMEOUT;
        end else begin
          idle_d = idle_inc;
        end
      end
    end else begin
      idle_d = '0;
      result_o.out_byte = c;
      if (position_q == '0) begin
        if (is_short || is_long) begin
          long_d     = !is_short;
          exp_len_d  = '0;
          cmd_d      = '0;
          position_d = 10'd1;
          result_o.status     = lpfr_pkg::ST_ACCEPT;
          result_o.long_frame = !is_short;
        end else begin
          result_o.status = lpfr_pkg::ST_STRAY;
        end
      end else if (position_q == 10'd1 || (position_q == 10'd2 && long_q)) begin
        result_o.byte_index   = position_q[lpfr_pkg::IdxW-1:0];
        result_o.frame_length = len_new;
        result_o.long_frame   = long_q;
        if (len_done && !len_ok) begin
          position_d = '0;
          exp_len_d  = '0;
          long_d     = 1'b0;
          cmd_d      = '0;
          result_o.status = lpfr_pkg::ST_BADLEN;
        end else begin
          position_d = pos_inc;
          exp_len_d  = len_new;
          result_o.status = lpfr_pkg::ST_ACCEPT;
        end
      end else begin
        result_o.byte_index   = position_q[lpfr_pkg::IdxW-1:0];
        result_o.frame_length = exp_len_q;
        result_o.long_frame   = long_q;
        if ({6'd0, pos_inc} == exp_len_q) begin
          position_d = '0;
          exp_len_d  = '0;
          long_d     = 1'b0;
          cmd_d      = '0;
          result_o.status       = lpfr_pkg::ST_DONE;
          result_o.command_code = cmd_now;
        end else begin
          position_d = pos_inc;
          cmd_d      = cmd_now;
          result_o.status = lpfr_pkg::ST_ACCEPT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      exp_len_q  <= '0;
      long_q     <= 1'b0;
      cmd_q      <= '0;
      idle_q     <= '0;
    end else if (step_i) begin
      position_q <= position_d;
      exp_len_q  <= exp_len_d;
      long_q     <= long_d;
      cmd_q      <= cmd_d;
      idle_q     <= idle_d;
    end
  end

endmodule

>>> design/length_prefixed_frame_receiver_core.sv
// ============================================================================
// length_prefixed_frame_receiver_core: start-byte framed stream receiver
// Delimits length-prefixed frames in a byte stream mixed with timer ticks.
// ============================================================================
// Usage:
//   Slave channel s_axis_*: one item per transaction. tuser = 1 marks a timer
//   tick, tuser = 0 a received byte carried in tdata.
//   Master channel m_axis_*: exactly one result per input item, in order.
//   tuser carries the status code; tdata carries the echoed byte, its index
//   in the frame, the decoded length, the long-frame flag and, on frame
//   complete, the command byte.
//   Configuration: write start bytes, timeout and maximum length through
//   cfg_we_i / cfg_index_i / cfg_data_i while no item is in flight.
// Pipeline and throughput:
//   An item passes the input register, then the frame decode into the
//   result register. One item per cycle sustained while m_axis_tready stays
//   high; the frame state update is a single short combinational step
//   between those two registers.
// Reset:
//   Registers return to their defaults (start bytes 0xFE and 0xFD, timeout
//   1000 ticks, maximum length 512) and the receiver waits for a start byte.
// Stall:
//   When m_axis_tready is low, the result holds, the input register fills,
//   and s_axis_tready drops once both stages are occupied; nothing is lost.
// ============================================================================
module length_prefixed_frame_receiver_core #(
  parameter int unsigned MAX_FRAME = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [lpfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lpfr_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tuser,  // [0] command
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] out_byte, [16:8] byte_index, [32:17] frame_length,
  // [33] long_frame, [41:34] command_code, [47:42] zero
  output logic [47:0]                   m_axis_tdata,
  output logic [2:0]                    m_axis_tuser   // [2:0] status
);

  lpfr_pkg::cfg_t    cfg;
  lpfr_pkg::item_t   in_q, in_d;
  lpfr_pkg::result_t res_q, res_d;
  logic              in_vld_q;
  logic              out_vld_q;
  logic              out_ready;
  logic              in_ready;
  logic              step;

  // result stage can take an item when empty or being drained
  assign out_ready = !out_vld_q || m_axis_tready;
  assign in_ready  = !in_vld_q || out_ready;
  assign step      = in_vld_q && out_ready;

  assign s_axis_tready = in_ready;

  assign in_d = '{command: lpfr_pkg::kind_e'(s_axis_tuser), data_byte: s_axis_tdata};

  lpfr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lpfr_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  // valid flags of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // payload: load input on a transaction, load result when the item advances
  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_q <= in_d;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {6'd0, res_q.command_code, res_q.long_frame,
                          res_q.frame_length, res_q.byte_index, res_q.out_byte};

endmodule

>>> verif/tb_length_prefixed_frame_receiver_core.sv
// ============================================================================
// tb_length_prefixed_frame_receiver_core: self-checking frame receiver bench
// Feeds bytes and timer ticks into the receiver, predicts every result with
// a cycle-free software parser of its own, and compares each result field by
// field. Directed frames cover the status codes and length corner cases, then
// random phases rewrite all four registers and mix well-formed frames with
// bad lengths, stale partial frames and stray noise under random back-pressure.
// ============================================================================
module tb_length_prefixed_frame_receiver_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_CAP    = 512;
  localparam int unsigned LONG_HOLD    = 400;      // sink hold-off in the stall phase
  localparam int unsigned DRAIN_CYCLES = 6;        // two-stage pipe plus margin
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 110;

  typedef logic [7:0] bytes_t[$];

  // --------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [lpfr_pkg::CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [lpfr_pkg::CfgDataW-1:0] cfg_data_i    = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata  = '0;  // [7:0] data_byte
  logic                          s_axis_tuser  = 1'b0; // [0] command
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // [7:0] out_byte, [16:8] byte_index, [32:17] frame_length,
  // [33] long_frame, [41:34] command_code
  logic [47:0]                   m_axis_tdata;
  logic [2:0]                    m_axis_tuser;        // [2:0] status

  length_prefixed_frame_receiver_core #(
    .MAX_FRAME (FRAME_CAP)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Parser shadow: register copies and frame state, advanced once per
  // accepted input transaction
  // --------------------------------------------------------------------------
  logic [7:0]  cfg_short;
  logic [7:0]  cfg_long;
  logic [15:0] cfg_tmo;
  logic [9:0]  cfg_max;

  logic [9:0]  rx_pos;      // bytes seen in the open frame, 0 = hunting
  logic [15:0] rx_len;
  logic        rx_long;
  logic [7:0]  rx_cmd;
  logic [15:0] rx_idle;

  function automatic void frame_clear();
    rx_pos  = '0;
    rx_len  = '0;
    rx_long = 1'b0;
    rx_cmd  = '0;
    rx_idle = '0;
  endfunction

  function automatic lpfr_pkg::result_t parse_step(lpfr_pkg::kind_e kind, logic [7:0] b);
    lpfr_pkg::result_t r;
    logic [15:0]       lim;
    logic [15:0]       need;
    logic              len_known;
    r = '0;
    r.status = lpfr_pkg::ST_NONE;
    // A tick only ages an open frame; past the allowance the frame is dropped.
    if (kind == lpfr_pkg::KIND_TICK) begin
      if (rx_pos != '0) begin
        if (rx_idle != lpfr_pkg::IDLE_SAT) rx_idle = rx_idle + 16'd1;
        if (rx_idle > cfg_tmo) begin
          frame_clear();
          r.status = lpfr_pkg::ST_TIMEOUT;
        end
      end
      return r;
    end
    rx_idle    = '0;
    r.out_byte = b;
    // Hunting for a start byte; the short one wins when both registers match.
    if (rx_pos == '0) begin
      if (b == cfg_short || b == cfg_long) begin
        rx_long      = (b != cfg_short);
        rx_len       = '0;
        rx_cmd       = '0;
        rx_pos       = 10'd1;
        r.status     = lpfr_pkg::ST_ACCEPT;
        r.long_frame = rx_long;
      end else begin
        r.status = lpfr_pkg::ST_STRAY;
      end
      return r;
    end
    r.byte_index = rx_pos[8:0];
    // Length bytes, big-endian for long frames; judge once the length is whole.
    if (rx_pos == 10'd1 || (rx_pos == 10'd2 && rx_long)) begin
      if (rx_pos == 10'd1) begin
        rx_len    = rx_long ? {b, 8'h00} : {8'h00, b};
        len_known = !rx_long;
      end else begin
        rx_len    = rx_len + {8'h00, b};
        len_known = 1'b1;
      end
      lim  = (cfg_max > FRAME_CAP) ? 16'(FRAME_CAP) : {6'd0, cfg_max};
      need = rx_long ? lpfr_pkg::MIN_LEN_LONG : lpfr_pkg::MIN_LEN_SHORT;
      r.frame_length = rx_len;
      r.long_frame   = rx_long;
      if (len_known && (rx_len < need || rx_len > lim)) begin
        frame_clear();
        r.status = lpfr_pkg::ST_BADLEN;
        return r;
      end
      rx_pos   = rx_pos + 10'd1;
      r.status = lpfr_pkg::ST_ACCEPT;
      return r;
    end
    // Body: capture the command byte, close the frame when the count hits length.
    if (rx_pos == (rx_long ? lpfr_pkg::CMD_OFS_LONG : lpfr_pkg::CMD_OFS_SHORT)) rx_cmd = b;
    rx_pos         = rx_pos + 10'd1;
    r.frame_length = rx_len;
    r.long_frame   = rx_long;
    if ({6'd0, rx_pos} == rx_len) begin
      r.status       = lpfr_pkg::ST_DONE;
      r.command_code = rx_cmd;
      frame_clear();
    end else begin
      r.status = lpfr_pkg::ST_ACCEPT;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Queues, counters and idling knobs
  // --------------------------------------------------------------------------
  lpfr_pkg::item_t   stream_items[$];    // bytes and ticks waiting for the driver
  lpfr_pkg::result_t awaited_results[$]; // predictions not yet matched
  lpfr_pkg::item_t   next_item;
  lpfr_pkg::result_t want;
  int unsigned queued_count  = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen  = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_gap_max  = 0;
  int unsigned sink_gap_max  = 0;
  int unsigned send_gap      = 0;
  int unsigned sink_gap      = 0;
  int unsigned hold_asks     = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  logic        send_taken    = 1'b0;
  logic        sink_taken    = 1'b0;

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("MISMATCH @%0t result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got_v, logic [15:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got_v, want_v));
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the next item at the falling edge once the slot is free;
  // the gap drawn with an item is spent before the following one
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (send_taken || !s_axis_tvalid) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (stream_items.size() != 0) begin
          next_item = stream_items.pop_front();
          s_axis_tdata  <= next_item.data_byte;
          s_axis_tuser  <= next_item.command;
          s_axis_tvalid <= 1'b1;
          send_gap = $urandom_range(send_gap_max, 0);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink: random per-result stalls, plus a long hold-off on request that is
  // counted here so the sender keeps pushing into a full pipe
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (sink_taken) sink_gap = $urandom_range(sink_gap_max, 0);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at the rising edge, check a result transaction against the
  // oldest prediction, then predict for an input transaction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    send_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    sink_taken <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("result arrived with nothing outstanding");
      end else begin
        want = awaited_results.pop_front();
        check_field("status", m_axis_tuser, want.status);
        check_field("out_byte", m_axis_tdata[7:0], want.out_byte);
        check_field("byte_index", m_axis_tdata[16:8], want.byte_index);
        check_field("frame_length", m_axis_tdata[32:17], want.frame_length);
        check_field("long_frame", m_axis_tdata[33], want.long_frame);
        check_field("command_code", m_axis_tdata[41:34], want.command_code);
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      awaited_results.push_back(parse_step(lpfr_pkg::kind_e'(s_axis_tuser), s_axis_tdata));
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_byte(logic [7:0] b);
    lpfr_pkg::item_t it;
    it.command   = lpfr_pkg::KIND_BYTE;
    it.data_byte = b;
    stream_items.push_back(it);
    queued_count++;
  endtask

  // Ticks carry a random don't-care byte.
  task automatic queue_ticks(int unsigned n);
    lpfr_pkg::item_t it;
    it.command = lpfr_pkg::KIND_TICK;
    repeat (n) begin
      it.data_byte = 8'($urandom);
      stream_items.push_back(it);
      queued_count++;
    end
  endtask

  // Idle stretch that never trips the timeout, sometimes exactly at the edge.
  function automatic int unsigned quiet_ticks();
    if (cfg_tmo <= 40 && $urandom_range(3, 0) == 0) return cfg_tmo;
    return $urandom_range((cfg_tmo < 3) ? cfg_tmo : 3, 0);
  endfunction

  function automatic logic [7:0] stray_value();
    logic [7:0] v;
    do v = 8'($urandom);
    while (v == cfg_short || v == cfg_long);
    return v;
  endfunction

  // Start byte, length field, then random body up to nbytes in total.
  task automatic build_frame(input bit lng, input int unsigned len_field,
                             input int unsigned nbytes, output bytes_t fb);
    logic [15:0] l16;
    l16 = 16'(len_field);
    fb = {};
    if (lng) begin
      fb.push_back(cfg_long);
      fb.push_back(l16[15:8]);
      fb.push_back(l16[7:0]);
    end else begin
      fb.push_back(cfg_short);
      fb.push_back(l16[7:0]);
    end
    while (fb.size() < nbytes) fb.push_back(8'($urandom));
  endtask

  task automatic push_frame(bytes_t fb, int unsigned count, bit pauses);
    for (int unsigned i = 0; i < count; i++) begin
      if (pauses && i != 0 && $urandom_range(5, 0) == 0) queue_ticks(quiet_ticks());
      queue_byte(fb[i]);
    end
  endtask

  task automatic write_reg(logic [lpfr_pkg::CfgIdxW-1:0] idx,
                           logic [lpfr_pkg::CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    case (idx)
      lpfr_pkg::CFG_SHORT_START: cfg_short = value[7:0];
      lpfr_pkg::CFG_LONG_START:  cfg_long  = value[7:0];
      lpfr_pkg::CFG_TIMEOUT:     cfg_tmo   = value;
      lpfr_pkg::CFG_MAX_LEN:     cfg_max   = value[9:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold the sender until every prediction has been matched.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (stream_items.size() != 0 || s_axis_tvalid || awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Rewrite all four registers; upper data bits are random to exercise masking.
  task automatic setup_phase(int unsigned ph);
    logic [7:0]  s_val;
    logic [7:0]  l_val;
    logic [15:0] t_val;
    logic [9:0]  m_val;
    s_val = 8'($urandom);
    l_val = 8'($urandom);
    t_val = 16'($urandom_range(6, 1));
    m_val = 10'($urandom_range(300, 6));
    case (ph)
      0: begin s_val = lpfr_pkg::RST_SHORT_START; l_val = lpfr_pkg::RST_LONG_START; end
      1: begin s_val = 8'h00; l_val = 8'hFF; t_val = 16'd1; m_val = 10'd4; end
      2: begin s_val = 8'hFF; l_val = 8'h00; t_val = 16'hFFFF; m_val = 10'd512; end
      3: m_val = 10'h3FF;
      4: l_val = s_val;
      5: t_val = 16'd0;
      6: t_val = 16'd40;
      7: m_val = 10'd5;
      default: ;
    endcase
    write_reg(lpfr_pkg::CFG_SHORT_START, {8'($urandom), s_val});
    write_reg(lpfr_pkg::CFG_LONG_START, {8'($urandom), l_val});
    write_reg(lpfr_pkg::CFG_TIMEOUT, t_val);
    write_reg(lpfr_pkg::CFG_MAX_LEN, {6'($urandom), m_val});
  endtask

  // Mostly well-formed frames; the rest are bad lengths, stale partial frames
  // and stray bytes with ticks between frames.
  task automatic random_traffic(int unsigned budget);
    int unsigned first;
    int unsigned pick;
    int unsigned need;
    int unsigned top;
    int unsigned len;
    bit          lng;
    bytes_t      fb;
    first = queued_count;
    while (queued_count - first < budget) begin
      pick = $urandom_range(99, 0);
      lng  = (cfg_short != cfg_long) && ($urandom_range(9, 0) < 3);
      need = lng ? 4 : 3;
      top  = (cfg_max > FRAME_CAP) ? FRAME_CAP : cfg_max;
      if (!lng && top > 255) top = 255;
      if ($urandom_range(199, 0) < 3) len = top;
      else if ($urandom_range(9, 0) == 0) len = $urandom_range((top < 64) ? top : 64, need);
      else len = $urandom_range((top < 24) ? top : 24, need);
      if (pick < 65) begin
        build_frame(lng, len, len, fb);
        push_frame(fb, len, 1'b1);
      end else if (pick < 75) begin
        if ($urandom_range(1, 0) == 1 && top < (lng ? 65535 : 255))
          len = $urandom_range(lng ? 65535 : 255, top + 1);
        else
          len = $urandom_range(need - 1, 0);
        build_frame(lng, len, lng ? 3 : 2, fb);
        push_frame(fb, fb.size(), 1'b0);
      end else if (pick < 85 && cfg_tmo <= 40) begin
        build_frame(lng, len, $urandom_range(len - 1, 1), fb);
        push_frame(fb, fb.size(), 1'b1);
        queue_ticks(cfg_tmo + 1);
      end else begin
        repeat ($urandom_range(4, 1)) queue_byte(stray_value());
        queue_ticks($urandom_range(3, 0));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    bytes_t fb;
    cfg_short = lpfr_pkg::RST_SHORT_START;
    cfg_long  = lpfr_pkg::RST_LONG_START;
    cfg_tmo   = lpfr_pkg::RST_TIMEOUT;
    cfg_max   = lpfr_pkg::RST_MAX_LEN;
    frame_clear();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset registers first.
    send_gap_max = 13;
    sink_gap_max = 13;
    queue_ticks(1);                           // tick while hunting
    queue_byte(8'h00);                        // stray bytes at both extremes
    queue_byte(8'hFF);
    queue_byte(8'hFE); queue_byte(8'd3); queue_byte(8'hA5);                   // shortest short
    queue_byte(8'hFD); queue_byte(8'd0); queue_byte(8'd4); queue_byte(8'h5A); // shortest long
    queue_byte(8'hFE); queue_byte(8'd2);                                      // short too short
    queue_byte(8'hFD); queue_byte(8'd0); queue_byte(8'd3);                    // long too short
    queue_byte(8'hFD); queue_byte(8'hFF); queue_byte(8'hFF);                  // length 65535
    queue_byte(8'hFD); queue_byte(8'h02); queue_byte(8'h01);                  // one past the cap
    wait_idle();

    // Equal start bytes open a short frame; zero allowance times out at once.
    write_reg(lpfr_pkg::CFG_SHORT_START, 16'h0055);
    write_reg(lpfr_pkg::CFG_LONG_START, 16'h0055);
    write_reg(lpfr_pkg::CFG_TIMEOUT, 16'd0);
    queue_byte(8'h55);
    queue_ticks(1);

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      setup_phase(ph);
      case (ph % 3)
        0: begin send_gap_max = 13; sink_gap_max = 13; end
        1: begin send_gap_max = 13; sink_gap_max = 0; end
        default: begin send_gap_max = 0; sink_gap_max = 13; end
      endcase
      if (ph == 6) begin
        send_gap_max = 0;
        sink_gap_max = 0;
      end
      // Back-pressure phase: sink holds off while the sender streams flat out.
      if (ph == 3) begin
        send_gap_max = 0;
        sink_gap_max = 0;
        hold_asks++;
      end
      // Largest frames of each kind walk byte_index through all its bits.
      if (ph == 2) begin
        build_frame(1'b1, FRAME_CAP, FRAME_CAP, fb);
        push_frame(fb, FRAME_CAP, 1'b0);
        build_frame(1'b0, 255, 255, fb);
        push_frame(fb, 255, 1'b1);
      end
      random_traffic(PHASE_ITEMS);
    end

    wait_idle();
    if (awaited_results.size() != 0) report_mismatch("predictions left unmatched");
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
design/lpfr_pkg.sv
design/lpfr_cfg_regs.sv
design/lpfr_parser.sv
design/length_prefixed_frame_receiver_core.sv
verif/tb_length_prefixed_frame_receiver_core.sv
